>>> rtl/waypoint_heading_follower_core_macros.svh
// ----------------------------------------------------------------------------
// Waypoint heading follower assertion macros
// Shared concurrent assertion forms for the follower RTL.
// ----------------------------------------------------------------------------
`ifndef WAYPOINT_HEADING_FOLLOWER_CORE_MACROS_SVH
`define WAYPOINT_HEADING_FOLLOWER_CORE_MACROS_SVH

// same-cycle implication
`define WHF_ASSERT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define WHF_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/whf_pkg.sv
// ----------------------------------------------------------------------------
// Waypoint heading follower package
// Sizes, codes, angle constants and small helper functions.
// ----------------------------------------------------------------------------
package whf_pkg;

   localparam int LIST_DEPTH   = 256;
   localparam int CORDIC_STEPS = 16;

   localparam int ADDR_W      = $clog2(LIST_DEPTH);
   localparam int CNT_W       = $clog2(LIST_DEPTH + 1);
   localparam int STEP_W      = $clog2(CORDIC_STEPS);
   localparam int CORDIC_IN_W = 34;
   localparam int CORDIC_W    = 46;
   localparam int Z_W         = 20;
   localparam int ANGLE_W     = 16;

   localparam logic [1:0] CMD_LOAD   = 2'd0;
   localparam logic [1:0] CMD_COMMIT = 2'd1;
   localparam logic [1:0] CMD_ODOM   = 2'd2;
   localparam logic [1:0] CMD_TICK   = 2'd3;

   localparam logic [1:0] KIND_DRIVE = 2'd0;
   localparam logic [1:0] KIND_STOP  = 2'd1;
   localparam logic [1:0] KIND_END   = 2'd2;

   localparam logic [1:0] CSR_DRIVE_SPEED    = 2'd0;
   localparam logic [1:0] CSR_TURN_GAIN      = 2'd1;
   localparam logic [1:0] CSR_ARRIVAL_RADIUS = 2'd2;

   localparam logic signed [ANGLE_W-1:0] PI_Q13   = 16'sd25736;
   localparam logic signed [Z_W-1:0]     PI_Q16   = 20'sd205887;
   localparam logic [32:0]               PI09_Q13 = 33'd23162;

   function automatic logic signed [Z_W-1:0] atan_q16(input logic [4:0] i);
      logic signed [Z_W-1:0] v;
      unique case (i)
         5'd0:    v = 20'sd51472;
         5'd1:    v = 20'sd30386;
         5'd2:    v = 20'sd16055;
         5'd3:    v = 20'sd8150;
         5'd4:    v = 20'sd4091;
         5'd5:    v = 20'sd2047;
         5'd6:    v = 20'sd1024;
         5'd7:    v = 20'sd512;
         5'd8:    v = 20'sd256;
         5'd9:    v = 20'sd128;
         5'd10:   v = 20'sd64;
         5'd11:   v = 20'sd32;
         5'd12:   v = 20'sd16;
         5'd13:   v = 20'sd8;
         5'd14:   v = 20'sd4;
         5'd15:   v = 20'sd2;
         5'd16:   v = 20'sd1;
         default: v = 20'sd0;
      endcase
      return v;
   endfunction

   // ||ang| - pi| * 40 < |ang|
   function automatic logic near_pi(input logic signed [ANGLE_W-1:0] ang);
      logic signed [23:0] a;
      logic signed [23:0] d;
      a = ang[ANGLE_W-1] ? -24'(ang) : 24'(ang);
      d = (a - 24'(PI_Q13)) * 24'sd40;
      return (d < a) && (d > -a);
   endfunction

endpackage

>>> rtl/whf_cordic.sv
// ----------------------------------------------------------------------------
// Waypoint heading follower CORDIC
// Vectoring CORDIC for atan2, one rotation per cycle, Q3.13 result.
// ----------------------------------------------------------------------------
`include "waypoint_heading_follower_core_macros.svh"

module whf_cordic (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    start,
   input  logic signed [whf_pkg::CORDIC_IN_W-1:0]  y_in,
   input  logic signed [whf_pkg::CORDIC_IN_W-1:0]  x_in,
   output logic                                    busy,
   output logic                                    done,
   output logic signed [whf_pkg::ANGLE_W-1:0]      angle
);

   logic                                   busy_ff;
   logic                                   done_ff;
   logic [whf_pkg::STEP_W-1:0]             step_ff;
   logic signed [whf_pkg::CORDIC_W-1:0]    x_ff;
   logic signed [whf_pkg::CORDIC_W-1:0]    y_ff;
   logic signed [whf_pkg::Z_W-1:0]         z_ff;
   logic signed [whf_pkg::ANGLE_W-1:0]     angle_ff;

   logic signed [whf_pkg::CORDIC_W-1:0]    x_sh;
   logic signed [whf_pkg::CORDIC_W-1:0]    y_sh;
   logic signed [whf_pkg::CORDIC_W-1:0]    x_rot;
   logic signed [whf_pkg::CORDIC_W-1:0]    y_rot;
   logic signed [whf_pkg::Z_W-1:0]         z_rot;
   logic signed [whf_pkg::Z_W-1:0]         z_rnd;
   logic signed [whf_pkg::ANGLE_W-1:0]     angle_in;
   logic signed [whf_pkg::CORDIC_W-1:0]    x_start;
   logic signed [whf_pkg::CORDIC_W-1:0]    y_start;
   logic                                   last_step;

   assign x_start   = whf_pkg::CORDIC_W'(x_in) <<< 8;
   assign y_start   = whf_pkg::CORDIC_W'(y_in) <<< 8;
   assign last_step = (step_ff == whf_pkg::STEP_W'(whf_pkg::CORDIC_STEPS - 1));

   always_comb begin
      x_sh = x_ff >>> step_ff;
      y_sh = y_ff >>> step_ff;
      if (y_ff > 0) begin
         x_rot = x_ff + y_sh;
         y_rot = y_ff - x_sh;
         z_rot = z_ff + whf_pkg::atan_q16(5'(step_ff));
      end else begin
         x_rot = x_ff - y_sh;
         y_rot = y_ff + x_sh;
         z_rot = z_ff - whf_pkg::atan_q16(5'(step_ff));
      end
      z_rnd = (z_rot + 20'sd4) >>> 3;
      if (z_rnd > whf_pkg::Z_W'(whf_pkg::PI_Q13)) begin
         angle_in = whf_pkg::PI_Q13;
      end else if (z_rnd < -whf_pkg::Z_W'(whf_pkg::PI_Q13)) begin
         angle_in = -whf_pkg::PI_Q13;
      end else begin
         angle_in = whf_pkg::ANGLE_W'(z_rnd);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start && !busy_ff) begin
            if (y_in == '0) begin
               done_ff <= 1'b1;
            end else begin
               busy_ff <= 1'b1;
            end
         end else if (busy_ff && last_step) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start && !busy_ff) begin
         step_ff <= '0;
         if (y_in == '0) begin
            angle_ff <= (x_in < 0) ? whf_pkg::PI_Q13 : '0;
         end else if (x_in < 0) begin
            x_ff <= -x_start;
            y_ff <= -y_start;
            z_ff <= (y_in >= 0) ? whf_pkg::PI_Q16 : -whf_pkg::PI_Q16;
         end else begin
            x_ff <= x_start;
            y_ff <= y_start;
            z_ff <= '0;
         end
      end else if (busy_ff) begin
         x_ff    <= x_rot;
         y_ff    <= y_rot;
         z_ff    <= z_rot;
         step_ff <= step_ff + 1'b1;
         if (last_step) begin
            angle_ff <= angle_in;
         end
      end
   end

   assign busy  = busy_ff;
   assign done  = done_ff;
   assign angle = angle_ff;

   `WHF_ASSERT(a_start_idle, clock, reset, start, !busy_ff, "cordic started while busy")
   `WHF_ASSERT(a_done_free, clock, reset, done_ff, !busy_ff, "cordic done while busy")

endmodule

>>> rtl/waypoint_heading_follower_core.sv
// ----------------------------------------------------------------------------
// Waypoint heading follower core
// Waypoint list, arrival check, yaw and bearing by a shared CORDIC and
// proportional turn command from a shared multiplier.
// ----------------------------------------------------------------------------
// Load and commit items are handled in the idle state. An odometry item and a
// control tick step through the one-rotation-per-cycle CORDIC and the
// single 33 x 33 multiplier, which forms the squares and quaternion
// products. Input is stalled while an odometry item or tick is in progress;
// a result waits in the output register until it is taken.
`include "waypoint_heading_follower_core_macros.svh"

module waypoint_heading_follower_core (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [1:0]         req_cmd,
   input  logic [7:0]         req_entry_index,
   input  logic [8:0]         req_list_count,
   input  logic signed [31:0] req_pos_x,
   input  logic signed [31:0] req_pos_y,
   input  logic signed [15:0] req_quat_w,
   input  logic signed [15:0] req_quat_x,
   input  logic signed [15:0] req_quat_y,
   input  logic signed [15:0] req_quat_z,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [1:0]         rsp_kind,
   output logic [15:0]        rsp_linear_speed,
   output logic signed [31:0] rsp_angular_turn,
   output logic               rsp_turn_held,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [1:0]         csr_index,
   input  logic [31:0]        csr_data
);

   typedef enum logic [3:0] {
      S_IDLE, S_ODO_READ, S_ODO_DIST, S_ODO_MUL, S_ODO_ANG,
      S_TICK_READ, S_TICK_DIFF, S_TICK_ANG, S_TICK_MUL, S_TICK_TURN, S_EMIT
   } state_type;

   localparam logic [3:0]  ODO_LAST  = 4'd10;
   localparam logic [3:0]  TICK_LAST = 4'd3;
   localparam logic [32:0] PI_LIMIT  = whf_pkg::PI09_Q13;

   state_type                        state_ff;
   logic [3:0]                       step_ff;
   logic [3:0]                       tag_ff;
   logic                             tag_valid_ff;
   logic signed [65:0]               prod_ff;

   logic [15:0]                      drive_speed_ff;
   logic [15:0]                      turn_gain_ff;
   logic [30:0]                      arrival_radius_ff;
   logic [whf_pkg::CNT_W-1:0]        list_length_ff;
   logic [whf_pkg::CNT_W-1:0]        target_slot_ff;
   logic                             target_valid_ff;
   logic                             ticking_ff;
   logic signed [31:0]               robot_x_ff;
   logic signed [31:0]               robot_y_ff;
   logic signed [15:0]               heading_ff;
   logic signed [31:0]               held_turn_ff;

   logic [63:0]                      mem [whf_pkg::LIST_DEPTH];
   logic [63:0]                      rd_ff;

   logic signed [31:0]               new_x_ff;
   logic signed [31:0]               new_y_ff;
   logic signed [15:0]               qw_ff;
   logic signed [15:0]               qx_ff;
   logic signed [15:0]               qy_ff;
   logic signed [15:0]               qz_ff;
   logic [30:0]                      dx_ff;
   logic [30:0]                      dy_ff;
   logic                             in_range_ff;
   logic [63:0]                      dist_ff;
   logic [61:0]                      rsq_ff;
   logic signed [32:0]               num_ff;
   logic signed [32:0]               den_ff;
   logic                             hit_ff;
   logic signed [15:0]               bearing_ff;
   logic signed [33:0]               turn_prod_ff;
   logic [30:0]                      limit_ff;

   logic [1:0]                       pend_kind_ff;
   logic [15:0]                      pend_speed_ff;
   logic signed [31:0]               pend_turn_ff;
   logic                             pend_held_ff;

   logic                             rsp_valid_ff;
   logic [1:0]                       rsp_kind_ff;
   logic [15:0]                      rsp_speed_ff;
   logic signed [31:0]               rsp_turn_ff;
   logic                             rsp_held_ff;

   logic                             req_xfer;
   logic                             active;
   logic [31:0]                      idx_wide;
   logic [31:0]                      cnt_wide;
   logic [31:0]                      cnt_sat;
   logic signed [31:0]               wp_x;
   logic signed [31:0]               wp_y;
   logic signed [32:0]               diff_x;
   logic signed [32:0]               diff_y;
   logic [32:0]                      abs_x;
   logic [32:0]                      abs_y;
   logic signed [32:0]               mul_a;
   logic signed [32:0]               mul_b;
   logic signed [65:0]               mul_p;
   logic                             mul_issue;
   logic signed [16:0]               head_diff;
   logic signed [33:0]               turn_rnd;
   logic [33:0]                      turn_abs;
   logic                             turn_big;
   logic                             hit_now;
   logic                             cordic_start;
   logic signed [whf_pkg::CORDIC_IN_W-1:0] cordic_y;
   logic signed [whf_pkg::CORDIC_IN_W-1:0] cordic_x;
   logic                             cordic_busy;
   logic                             cordic_done;
   logic signed [15:0]               cordic_angle;

   assign req_stall = (state_ff != S_IDLE);
   assign req_xfer  = req_valid && !req_stall;
   assign csr_ready = 1'b1;
   assign active    = target_valid_ff && (target_slot_ff < list_length_ff);
   assign idx_wide  = 32'(req_entry_index);
   assign cnt_wide  = 32'(req_list_count);
   assign cnt_sat   = (cnt_wide > 32'(whf_pkg::LIST_DEPTH)) ?
                      32'(whf_pkg::LIST_DEPTH) : cnt_wide;

   assign wp_x   = rd_ff[31:0];
   assign wp_y   = rd_ff[63:32];
   assign diff_x = 33'(robot_x_ff) - 33'(wp_x);
   assign diff_y = 33'(robot_y_ff) - 33'(wp_y);
   assign abs_x  = diff_x[32] ? 33'(-diff_x) : 33'(diff_x);
   assign abs_y  = diff_y[32] ? 33'(-diff_y) : 33'(diff_y);

   assign head_diff = 17'(bearing_ff) - 17'(heading_ff);
   assign turn_rnd  = (turn_prod_ff + 34'sd128) >>> 8;
   assign turn_abs  = turn_rnd[33] ? 34'(-turn_rnd) : 34'(turn_rnd);
   assign turn_big  = ((turn_abs << 8) >= 34'(limit_ff)) && (held_turn_ff != 0);
   assign hit_now   = in_range_ff && (dist_ff <= 64'(rsq_ff));

   // shared multiplier operand select
   always_comb begin
      mul_a     = '0;
      mul_b     = '0;
      mul_issue = 1'b0;
      if (state_ff == S_ODO_MUL) begin
         mul_issue = (step_ff <= 4'd8);
         unique case (step_ff)
            4'd0: begin
               mul_a = $signed({2'b0, dx_ff});
               mul_b = $signed({2'b0, dx_ff});
            end
            4'd1: begin
               mul_a = $signed({2'b0, dy_ff});
               mul_b = $signed({2'b0, dy_ff});
            end
            4'd2: begin
               mul_a = $signed({2'b0, arrival_radius_ff});
               mul_b = $signed({2'b0, arrival_radius_ff});
            end
            4'd3: begin
               mul_a = 33'(qw_ff);
               mul_b = 33'(qz_ff);
            end
            4'd4: begin
               mul_a = 33'(qx_ff);
               mul_b = 33'(qy_ff);
            end
            4'd5: begin
               mul_a = 33'(qw_ff);
               mul_b = 33'(qw_ff);
            end
            4'd6: begin
               mul_a = 33'(qx_ff);
               mul_b = 33'(qx_ff);
            end
            4'd7: begin
               mul_a = 33'(qy_ff);
               mul_b = 33'(qy_ff);
            end
            4'd8: begin
               mul_a = 33'(qz_ff);
               mul_b = 33'(qz_ff);
            end
            default: begin
               mul_a = '0;
               mul_b = '0;
            end
         endcase
      end else if (state_ff == S_TICK_MUL) begin
         mul_issue = (step_ff <= 4'd1);
         mul_a     = $signed({17'b0, turn_gain_ff});
         mul_b     = (step_ff == 4'd0) ? 33'(head_diff) : $signed(PI_LIMIT);
      end
      mul_p = mul_a * mul_b;
   end

   always_comb begin
      cordic_start = 1'b0;
      cordic_y     = {num_ff, 1'b0};
      cordic_x     = 34'(den_ff);
      if (state_ff == S_ODO_MUL && step_ff == ODO_LAST) begin
         cordic_start = 1'b1;
      end else if (state_ff == S_TICK_DIFF) begin
         cordic_y     = 34'(-diff_y);
         cordic_x     = 34'(-diff_x);
         cordic_start = (diff_x != '0);
      end
   end

   whf_cordic u_cordic (
      .clock (clock),
      .reset (reset),
      .start (cordic_start),
      .y_in  (cordic_y),
      .x_in  (cordic_x),
      .busy  (cordic_busy),
      .done  (cordic_done),
      .angle (cordic_angle)
   );

   always_ff @(posedge clock) begin
      if (req_xfer && req_cmd == whf_pkg::CMD_LOAD &&
          idx_wide < 32'(whf_pkg::LIST_DEPTH)) begin
         mem[idx_wide[whf_pkg::ADDR_W-1:0]] <= {req_pos_y, req_pos_x};
      end
      rd_ff <= mem[target_slot_ff[whf_pkg::ADDR_W-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         drive_speed_ff    <= 16'd256;
         turn_gain_ff      <= 16'd384;
         arrival_radius_ff <= 31'd16384;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            whf_pkg::CSR_DRIVE_SPEED:    drive_speed_ff    <= csr_data[15:0];
            whf_pkg::CSR_TURN_GAIN:      turn_gain_ff      <= csr_data[15:0];
            whf_pkg::CSR_ARRIVAL_RADIUS: arrival_radius_ff <= csr_data[30:0];
            default: ;
         endcase
      end
   end

   // multiplier pipe and accumulators
   always_ff @(posedge clock) begin
      prod_ff <= mul_p;
      tag_ff  <= step_ff;
      if (state_ff == S_ODO_DIST) begin
         dist_ff <= '0;
         num_ff  <= '0;
         den_ff  <= '0;
      end else if (tag_valid_ff && state_ff == S_ODO_MUL) begin
         unique case (tag_ff)
            4'd0, 4'd1: dist_ff <= dist_ff + prod_ff[63:0];
            4'd2:       rsq_ff  <= prod_ff[61:0];
            4'd3, 4'd4: num_ff  <= num_ff + 33'(prod_ff);
            4'd5, 4'd6: den_ff  <= den_ff + 33'(prod_ff);
            4'd7, 4'd8: den_ff  <= den_ff - 33'(prod_ff);
            default: ;
         endcase
      end else if (tag_valid_ff && state_ff == S_TICK_MUL) begin
         if (tag_ff == 4'd0) begin
            turn_prod_ff <= 34'(prod_ff);
         end else begin
            limit_ff <= prod_ff[30:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= S_IDLE;
         step_ff         <= '0;
         tag_valid_ff    <= 1'b0;
         list_length_ff  <= '0;
         target_slot_ff  <= '0;
         target_valid_ff <= 1'b0;
         ticking_ff      <= 1'b0;
         robot_x_ff      <= '0;
         robot_y_ff      <= '0;
         heading_ff      <= '0;
         held_turn_ff    <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         tag_valid_ff <= mul_issue;
         if (rsp_valid_ff && !rsp_stall && state_ff != S_EMIT) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req_xfer) begin
                  new_x_ff <= req_pos_x;
                  new_y_ff <= req_pos_y;
                  qw_ff    <= req_quat_w;
                  qx_ff    <= req_quat_x;
                  qy_ff    <= req_quat_y;
                  qz_ff    <= req_quat_z;
                  unique case (req_cmd)
                     whf_pkg::CMD_LOAD: ;
                     whf_pkg::CMD_COMMIT: begin
                        if (!target_valid_ff) begin
                           ticking_ff <= 1'b1;
                        end
                        list_length_ff <= cnt_sat[whf_pkg::CNT_W-1:0];
                        if (cnt_sat != '0) begin
                           target_slot_ff  <= '0;
                           target_valid_ff <= 1'b1;
                        end
                     end
                     whf_pkg::CMD_ODOM: begin
                        if (active) begin
                           state_ff <= S_ODO_READ;
                        end
                     end
                     whf_pkg::CMD_TICK: begin
                        if (ticking_ff) begin
                           if (active) begin
                              state_ff <= S_TICK_READ;
                           end else begin
                              ticking_ff      <= 1'b0;
                              target_valid_ff <= 1'b0;
                              pend_kind_ff    <= whf_pkg::KIND_END;
                              pend_speed_ff   <= '0;
                              pend_turn_ff    <= '0;
                              pend_held_ff    <= 1'b0;
                              state_ff        <= S_EMIT;
                           end
                        end
                     end
                  endcase
               end
            end
            S_ODO_READ: state_ff <= S_ODO_DIST;
            S_ODO_DIST: begin
               dx_ff       <= abs_x[30:0];
               dy_ff       <= abs_y[30:0];
               in_range_ff <= (abs_x[32:31] == 2'b00) && (abs_y[32:31] == 2'b00);
               step_ff     <= '0;
               state_ff    <= S_ODO_MUL;
            end
            S_ODO_MUL: begin
               step_ff <= step_ff + 1'b1;
               if (step_ff == ODO_LAST) begin
                  hit_ff        <= hit_now;
                  pend_kind_ff  <= whf_pkg::KIND_STOP;
                  pend_speed_ff <= '0;
                  pend_turn_ff  <= '0;
                  pend_held_ff  <= 1'b0;
                  if (hit_now) begin
                     target_slot_ff <= target_slot_ff + 1'b1;
                  end
                  robot_x_ff <= new_x_ff;
                  robot_y_ff <= new_y_ff;
                  state_ff   <= S_ODO_ANG;
               end
            end
            S_ODO_ANG: begin
               if (cordic_done) begin
                  heading_ff <= whf_pkg::near_pi(cordic_angle) ? '0 : cordic_angle;
                  state_ff   <= hit_ff ? S_EMIT : S_IDLE;
               end
            end
            S_TICK_READ: state_ff <= S_TICK_DIFF;
            S_TICK_DIFF: begin
               step_ff <= '0;
               if (diff_x == '0) begin
                  bearing_ff <= '0;
                  state_ff   <= S_TICK_MUL;
               end else begin
                  state_ff <= S_TICK_ANG;
               end
            end
            S_TICK_ANG: begin
               if (cordic_done) begin
                  bearing_ff <= whf_pkg::near_pi(cordic_angle) ?
                                whf_pkg::PI_Q13 : cordic_angle;
                  state_ff   <= S_TICK_MUL;
               end
            end
            S_TICK_MUL: begin
               step_ff <= step_ff + 1'b1;
               if (step_ff == TICK_LAST) begin
                  state_ff <= S_TICK_TURN;
               end
            end
            S_TICK_TURN: begin
               pend_kind_ff  <= whf_pkg::KIND_DRIVE;
               pend_speed_ff <= drive_speed_ff;
               if (turn_big) begin
                  pend_turn_ff <= held_turn_ff;
                  pend_held_ff <= 1'b1;
               end else begin
                  pend_turn_ff <= 32'(turn_rnd);
                  pend_held_ff <= 1'b0;
                  held_turn_ff <= 32'(turn_rnd);
               end
               state_ff <= S_EMIT;
            end
            S_EMIT: begin
               if (!rsp_valid_ff || !rsp_stall) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_kind_ff  <= pend_kind_ff;
                  rsp_speed_ff <= pend_speed_ff;
                  rsp_turn_ff  <= pend_turn_ff;
                  rsp_held_ff  <= pend_held_ff;
                  state_ff     <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_kind         = rsp_kind_ff;
   assign rsp_linear_speed = rsp_speed_ff;
   assign rsp_angular_turn = rsp_turn_ff;
   assign rsp_turn_held    = rsp_held_ff;

   `WHF_ASSERT(a_rsp_from_emit, clock, reset, $rose(rsp_valid_ff), $past(state_ff) == S_EMIT, "result loaded outside emit")
   `WHF_ASSERT(a_cordic_owner, clock, reset, cordic_done, (state_ff == S_ODO_ANG) || (state_ff == S_TICK_ANG), "cordic result with no waiting step")
   `WHF_ASSERT_NEXT(a_commit_aim, clock, reset, req_xfer && (req_cmd == whf_pkg::CMD_COMMIT) && (req_list_count != '0), target_valid_ff && (target_slot_ff == '0), "commit did not aim at first slot")
   `WHF_ASSERT(a_cordic_free, clock, reset, state_ff == S_ODO_MUL, !cordic_busy, "cordic busy during multiply pass")

endmodule

>>> tb/sv/waypoint_heading_follower_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Waypoint heading follower core testbench
// Drives load, commit, odometry and tick transfers with random bursts and
// output back-pressure, predicts each drive, stop and end-of-list command in
// fixed point, and checks every result field against the prediction.
// ----------------------------------------------------------------------------
module waypoint_heading_follower_core_tb;

   localparam int  CLK_HALF   = 2;
   localparam int  LIMIT      = 1000000;
   localparam int  SETTLE     = 60;
   localparam int  MAX_REPORT = 10;
   localparam longint PI13  = 25736;
   localparam longint PI16  = 205887;
   localparam longint PI09  = 23162;
   localparam longint ATAN_TAB [0:23] = '{51472, 30386, 16055, 8150, 4091, 2047,
      1024, 512, 256, 128, 64, 32, 16, 8, 4, 2, 1, 0, 0, 0, 0, 0, 0, 0};

   typedef struct {
      logic [1:0]         cmd;
      logic [7:0]         idx;
      logic [8:0]         cnt;
      logic signed [31:0] x;
      logic signed [31:0] y;
      logic signed [15:0] qw;
      logic signed [15:0] qx;
      logic signed [15:0] qy;
      logic signed [15:0] qz;
   } nav_req_type;

   typedef struct {
      logic [1:0]         kind;
      logic [15:0]        speed;
      logic signed [31:0] turn;
      logic               held;
   } motion_cmd_type;

   logic               clock = 0;
   logic               reset = 1;
   logic               req_valid = 0;
   logic               req_stall;
   logic [1:0]         req_cmd = whf_pkg::CMD_LOAD;
   logic [7:0]         req_entry_index = 0;
   logic [8:0]         req_list_count = 0;
   logic signed [31:0] req_pos_x = 0;
   logic signed [31:0] req_pos_y = 0;
   logic signed [15:0] req_quat_w = 0;
   logic signed [15:0] req_quat_x = 0;
   logic signed [15:0] req_quat_y = 0;
   logic signed [15:0] req_quat_z = 0;
   logic               rsp_valid;
   logic               rsp_stall = 0;
   logic [1:0]         rsp_kind;
   logic [15:0]        rsp_linear_speed;
   logic signed [31:0] rsp_angular_turn;
   logic               rsp_turn_held;
   logic               csr_valid = 0;
   logic               csr_ready;
   logic [1:0]         csr_index = whf_pkg::CSR_DRIVE_SPEED;
   logic [31:0]        csr_data = 0;

   waypoint_heading_follower_core DUT (.*);

   initial begin
      forever #CLK_HALF clock = ~clock;
   end

   // follower state as predicted
   longint         wp_x [0:255];
   longint         wp_y [0:255];
   bit             wp_loaded [0:255];
   int             route_len, route_slot;
   bit             aimed, ticking;
   longint         bot_x, bot_y, bot_head, last_turn;
   longint         speed_cfg = 256, gain_cfg = 384, radius_cfg = 16384;
   motion_cmd_type motion_cmds_q [$];

   int  n_sent, n_drive, n_stop, n_end, n_held, n_mismatch, cycles;
   int  burst_left = 4;
   int  hold_ask;

   function automatic longint atan2_q13(longint y, longint x);
      longint z, r, xs, ys;
      z = 0;
      if (y == 0) return (x < 0) ? PI13 : 0;
      x = x * 256;
      y = y * 256;
      if (x < 0) begin
         z = (y >= 0) ? PI16 : -PI16;
         x = -x;
         y = -y;
      end
      for (int i = 0; i < whf_pkg::CORDIC_STEPS && i < 24; i++) begin
         xs = x >>> i;
         ys = y >>> i;
         if (y > 0) begin
            x = x + ys; y = y - xs; z = z + ATAN_TAB[i];
         end else begin
            x = x - ys; y = y + xs; z = z - ATAN_TAB[i];
         end
      end
      r = (z + 4) >>> 3;
      if (r > PI13) r = PI13;
      if (r < -PI13) r = -PI13;
      return r;
   endfunction

   function automatic bit close_to_pi(longint ang);
      longint a, d;
      a = (ang < 0) ? -ang : ang;
      d = (a - PI13) * 40;
      return (d < a) && (d > -a);
   endfunction

   function automatic void push_cmd(logic [1:0] kind, longint spd, longint turn, bit held);
      motion_cmd_type c;
      c.kind = kind;
      c.speed = spd[15:0];
      c.turn = turn[31:0];
      c.held = held;
      motion_cmds_q.push_back(c);
   endfunction

   function automatic void follow_step(nav_req_type it);
      longint dx, dy, num, den, h, wx, wy, brg, turn;
      int     cnt;
      case (it.cmd)
         whf_pkg::CMD_LOAD: begin
            wp_x[it.idx] = it.x;
            wp_y[it.idx] = it.y;
            wp_loaded[it.idx] = 1;
         end
         whf_pkg::CMD_COMMIT: begin
            if (!aimed) ticking = 1;
            cnt = (it.cnt > 256) ? 256 : it.cnt;
            route_len = cnt;
            if (cnt > 0) begin
               route_slot = 0;
               aimed = 1;
            end
         end
         whf_pkg::CMD_ODOM: begin
            if (aimed && route_slot < route_len) begin
               dx = bot_x - wp_x[route_slot];
               dy = bot_y - wp_y[route_slot];
               if (dx < 0) dx = -dx;
               if (dy < 0) dy = -dy;
               if (dx < 64'h8000_0000 && dy < 64'h8000_0000 &&
                   dx * dx + dy * dy <= radius_cfg * radius_cfg) begin
                  push_cmd(whf_pkg::KIND_STOP, 0, 0, 0);
                  route_slot++;
               end
               bot_x = it.x;
               bot_y = it.y;
               num = 2 * (longint'(it.qw) * it.qz + longint'(it.qx) * it.qy);
               den = longint'(it.qw) * it.qw + longint'(it.qx) * it.qx
                     - longint'(it.qy) * it.qy - longint'(it.qz) * it.qz;
               h = atan2_q13(num, den);
               bot_head = close_to_pi(h) ? 0 : h;
            end
         end
         default: begin
            if (ticking) begin
               if (!aimed || route_slot >= route_len) begin
                  ticking = 0;
                  aimed = 0;
                  push_cmd(whf_pkg::KIND_END, 0, 0, 0);
               end else begin
                  wx = wp_x[route_slot];
                  wy = wp_y[route_slot];
                  brg = (wx != bot_x) ? atan2_q13(wy - bot_y, wx - bot_x) : 0;
                  if (close_to_pi(brg)) brg = PI13;
                  turn = (gain_cfg * (brg - bot_head) + 128) >>> 8;
                  if (turn > 64'sd2147483647) turn = 64'sd2147483647;
                  if (turn < -64'sd2147483648) turn = -64'sd2147483648;
                  if (((turn < 0) ? -turn : turn) * 256 >= gain_cfg * PI09 &&
                      last_turn != 0) begin
                     push_cmd(whf_pkg::KIND_DRIVE, speed_cfg, last_turn, 1);
                  end else begin
                     last_turn = turn;
                     push_cmd(whf_pkg::KIND_DRIVE, speed_cfg, turn, 0);
                  end
               end
            end
         end
      endcase
   endfunction

   function automatic int loaded_prefix();
      int n = 0;
      while (n < 256 && wp_loaded[n]) n++;
      return n;
   endfunction

   function automatic nav_req_type mk(logic [1:0] cmd, logic [7:0] idx, logic [8:0] cnt,
                                      logic [31:0] x, logic [31:0] y,
                                      logic [15:0] qw, logic [15:0] qx,
                                      logic [15:0] qy, logic [15:0] qz);
      nav_req_type it;
      it.cmd = cmd; it.idx = idx; it.cnt = cnt; it.x = x; it.y = y;
      it.qw = qw; it.qx = qx; it.qy = qy; it.qz = qz;
      return it;
   endfunction

   function automatic nav_req_type noise_item();
      nav_req_type it;
      int          lim;
      it = mk($urandom, $urandom, $urandom, $urandom, $urandom,
              $urandom, $urandom, $urandom, $urandom);
      lim = loaded_prefix();
      if (it.cmd == whf_pkg::CMD_COMMIT && lim < 256 && it.cnt > lim)
         it.cnt = $urandom_range(0, lim);
      return it;
   endfunction

   task automatic send(nav_req_type it);
      int gap;
      @(negedge clock);
      req_cmd <= it.cmd; req_entry_index <= it.idx; req_list_count <= it.cnt;
      req_pos_x <= it.x; req_pos_y <= it.y;
      req_quat_w <= it.qw; req_quat_x <= it.qx;
      req_quat_y <= it.qy; req_quat_z <= it.qz;
      req_valid <= 1;
      do @(posedge clock); while (req_stall);
      follow_step(it);
      n_sent++;
      if (--burst_left == 0) begin
         burst_left = $urandom_range(1, 12);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            @(negedge clock);
            req_valid <= 0;
            repeat (gap - 1) @(negedge clock);
         end
      end
   endtask

   task automatic go_quiet();
      @(negedge clock);
      req_valid <= 0;
      wait (motion_cmds_q.size() == 0);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic csr_write(logic [1:0] index, logic [31:0] data);
      @(negedge clock);
      csr_valid <= 1; csr_index <= index; csr_data <= data;
      do @(posedge clock); while (!csr_ready);
      case (index)
         whf_pkg::CSR_DRIVE_SPEED: speed_cfg = data[15:0];
         whf_pkg::CSR_TURN_GAIN:   gain_cfg = data[15:0];
         default:                  radius_cfg = data[30:0];
      endcase
      @(negedge clock);
      csr_valid <= 0;
   endtask

   task automatic set_regs(logic [15:0] spd, logic [15:0] gain, logic [30:0] rad);
      go_quiet();
      csr_write(whf_pkg::CSR_DRIVE_SPEED, spd);
      csr_write(whf_pkg::CSR_TURN_GAIN, gain);
      csr_write(whf_pkg::CSR_ARRIVAL_RADIUS, rad);
   endtask

   // odometry near the current target so arrivals happen
   function automatic nav_req_type odom_near();
      longint bx, by, sp;
      if (aimed && route_slot < route_len) begin
         bx = wp_x[route_slot]; by = wp_y[route_slot];
      end else begin
         bx = bot_x; by = bot_y;
      end
      sp = (radius_cfg > 32'h0010_0000) ? 32'h0010_0000 : radius_cfg + 1;
      if ($urandom_range(0, 3) != 0) begin
         bx = bx + longint'($urandom_range(0, 2 * sp)) - sp;
         by = by + longint'($urandom_range(0, 2 * sp)) - sp;
      end
      return mk(whf_pkg::CMD_ODOM, $urandom, $urandom, bx, by,
                $urandom, $urandom, $urandom, $urandom);
   endfunction

   task automatic test_idle_behavior();
      send(mk(whf_pkg::CMD_TICK, 0, 0, 0, 0, 0, 0, 0, 0));
      send(mk(whf_pkg::CMD_ODOM, 0, 0, 100, 200, 16384, 0, 0, 0));
      send(mk(whf_pkg::CMD_COMMIT, 0, 0, 0, 0, 0, 0, 0, 0));
      send(mk(whf_pkg::CMD_TICK, 0, 0, 0, 0, 0, 0, 0, 0));
      send(mk(whf_pkg::CMD_TICK, 0, 0, 0, 0, 0, 0, 0, 0));
   endtask

   task automatic test_field_extremes();
      send(mk(whf_pkg::CMD_LOAD, 0, 0, 32'h7fff_ffff, 32'h8000_0000, 0, 0, 0, 0));
      send(mk(whf_pkg::CMD_LOAD, 1, 0, 32'h8000_0000, 32'h7fff_ffff, 0, 0, 0, 0));
      send(mk(whf_pkg::CMD_LOAD, 2, 0, 0, 0, 0, 0, 0, 0));
      send(mk(whf_pkg::CMD_LOAD, 3, 0, 0, 32'h0001_0000, 0, 0, 0, 0));
      send(mk(whf_pkg::CMD_LOAD, 4, 0, 32'h8000_0000, 0, 0, 0, 0, 0));
      send(mk(whf_pkg::CMD_COMMIT, 0, 5, 0, 0, 0, 0, 0, 0));
      send(mk(whf_pkg::CMD_TICK, 0, 0, 0, 0, 0, 0, 0, 0));
      // degenerate quaternion, then yaw of exactly pi
      send(mk(whf_pkg::CMD_ODOM, 0, 0, 32'h7fff_ffff, 32'h8000_0000, 0, 0, 0, 0));
      send(mk(whf_pkg::CMD_ODOM, 0, 0, 0, 0, 0, 0, 0, 16384));
      send(mk(whf_pkg::CMD_TICK, 0, 0, 0, 0, 0, 0, 0, 0));
      send(mk(whf_pkg::CMD_ODOM, 0, 0, 32'h8000_0000, 32'h7fff_ffff,
              16'h8000, 16'h8000, 16'h8000, 16'h8000));
      send(mk(whf_pkg::CMD_TICK, 0, 0, 0, 0, 0, 0, 0, 0));
      send(mk(whf_pkg::CMD_ODOM, 0, 0, 32'h7fff_0000, 32'h0000_0100,
              16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff));
      send(mk(whf_pkg::CMD_TICK, 0, 0, 0, 0, 0, 0, 0, 0));
      // target straight behind; same x as target
      send(mk(whf_pkg::CMD_ODOM, 0, 0, 16'h0100, 0, 16384, 0, 0, 0));
      send(mk(whf_pkg::CMD_TICK, 0, 0, 0, 0, 0, 0, 0, 0));
      send(mk(whf_pkg::CMD_ODOM, 0, 0, 32'h8000_0000, 32'h0000_4000, 0, 0, 0, 16384));
      send(mk(whf_pkg::CMD_TICK, 0, 0, 0, 0, 0, 0, 0, 0));
      send(mk(whf_pkg::CMD_ODOM, 0, 0, 0, 0, 0, 0, 0, 0));
      send(mk(whf_pkg::CMD_TICK, 0, 0, 0, 0, 0, 0, 0, 0));
      send(mk(whf_pkg::CMD_TICK, 0, 0, 0, 0, 0, 0, 0, 0));
   endtask

   task automatic test_full_list();
      for (int i = 0; i < 256; i++)
         send(mk(whf_pkg::CMD_LOAD, i, 0,
                 $urandom_range(0, 32'h003f_ffff) - 32'h0020_0000,
                 $urandom_range(0, 32'h003f_ffff) - 32'h0020_0000, 0, 0, 0, 0));
      send(mk(whf_pkg::CMD_COMMIT, 0, 9'h1ff, 0, 0, 0, 0, 0, 0));
      repeat (6) begin
         send(odom_near());
         send(mk(whf_pkg::CMD_TICK, 0, 0, 0, 0, 0, 0, 0, 0));
      end
   endtask

   task automatic run_routes(int n_items);
      int stop_at, k, pick;
      stop_at = n_sent + n_items;
      while (n_sent < stop_at) begin
         if (!ticking) begin
            k = $urandom_range(1, 8);
            for (int i = 0; i < k; i++)
               send(mk(whf_pkg::CMD_LOAD, i, 0,
                       $urandom_range(0, 32'h000f_ffff) - 32'h0008_0000,
                       $urandom_range(0, 32'h000f_ffff) - 32'h0008_0000, 0, 0, 0, 0));
            send(mk(whf_pkg::CMD_COMMIT, 0, ($urandom_range(0, 9) == 0) ? 0 : k,
                    0, 0, 0, 0, 0, 0));
         end else begin
            pick = $urandom_range(0, 99);
            if (pick < 45)      send(odom_near());
            else if (pick < 85) send(mk(whf_pkg::CMD_TICK, $urandom, $urandom, $urandom,
                                        $urandom, $urandom, $urandom, $urandom,
                                        $urandom));
            else                send(noise_item());
         end
      end
   endtask

   task automatic test_register_sweep();
      set_regs(16'hffff, 16'hffff, 31'h7fff_ffff);
      run_routes(120);
      set_regs(16'h0000, 16'h0000, 31'h0000_0000);
      run_routes(120);
      set_regs(16'h1234, 16'h0001, 31'h0000_0001);
      run_routes(100);
      set_regs($urandom, $urandom_range(256, 4096), $urandom_range(8192, 200000));
      run_routes(100);
   endtask

   task automatic test_output_hold();
      hold_ask = 400;
      run_routes(40);
      go_quiet();
      run_routes(30);
   endtask

   task automatic test_random_routes();
      set_regs(256, 384, 16384);
      run_routes(350);
      set_regs($urandom, $urandom, $urandom_range(4096, 1 << 20));
      run_routes(200);
   endtask

   // receiver stall pattern with an occasional long hold
   initial begin
      int  run_left = 0, hold_left = 0;
      bit  st = 0;
      forever begin
         @(negedge clock);
         if (hold_ask > 0) begin
            hold_left = hold_ask;
            hold_ask = 0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1;
         end else begin
            if (run_left == 0) begin
               st = !st;
               run_left = st ? $urandom_range(1, 5) : $urandom_range(1, 30);
            end
            run_left--;
            rsp_stall <= st;
         end
      end
   end

   always @(posedge clock) begin
      motion_cmd_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (motion_cmds_q.size() == 0) begin
            n_mismatch++;
            if (n_mismatch <= MAX_REPORT)
               $display("unexpected transfer: kind %0d speed %0d turn %0d held %0d",
                        rsp_kind, rsp_linear_speed, rsp_angular_turn, rsp_turn_held);
         end else begin
            e = motion_cmds_q.pop_front();
            case (e.kind)
               whf_pkg::KIND_DRIVE: n_drive++;
               whf_pkg::KIND_STOP:  n_stop++;
               default:             n_end++;
            endcase
            if (e.held) n_held++;
            if (rsp_kind !== e.kind || rsp_linear_speed !== e.speed ||
                rsp_angular_turn !== e.turn || rsp_turn_held !== e.held) begin
               n_mismatch++;
               if (n_mismatch <= MAX_REPORT)
                  $display("mismatch: exp kind %0d speed %0d turn %0d held %0d, got %0d %0d %0d %0d",
                           e.kind, e.speed, e.turn, e.held, rsp_kind, rsp_linear_speed,
                           rsp_angular_turn, rsp_turn_held);
            end
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("waypoint_heading_follower_core regression: fail");
         $finish;
      end
   end

   initial begin
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 0;
      test_idle_behavior();
      test_field_extremes();
      go_quiet();
      test_full_list();
      test_register_sweep();
      test_output_hold();
      test_random_routes();
      go_quiet();
      $display("sent %0d items; drive %0d (held %0d), stop %0d, end-of-list %0d",
               n_sent, n_drive, n_held, n_stop, n_end);
      $display("covered idle ticks, extreme fields, full list, register extremes, hold");
      if (n_mismatch == 0 && motion_cmds_q.size() == 0) begin
         $display("waypoint_heading_follower_core regression: pass");
      end else begin
         $display("%0d mismatches, %0d expectations left", n_mismatch, motion_cmds_q.size());
         $display("waypoint_heading_follower_core regression: fail");
      end
      $finish;
   end

endmodule
